@@ rtl/lvc_pkg.sv @@
// shared constants, types and field widths for the lru value cache
`default_nettype none

package lvc_pkg;

  // cache geometry
  localparam int ENTRIES   = 16;
  localparam int KEY_WIDTH = 64;

  // derived index, rank and count widths
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  // fixed field widths on the ports
  localparam int KEY_PORT_W   = 64;
  localparam int KIND_W       = 3;
  localparam int SLOT_W       = 4;
  localparam int IN_TDATA_W   = 64;
  localparam int USER_W       = 8;
  localparam int OUT_FIELDS_W = 1 + SLOT_W + 1 + KEY_PORT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // oldest rank among a full set of slots
  localparam int OLDEST_RANK = ENTRIES - 1;

  // result of the associative search, store to datapath and recency logic
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             full;
    logic [CNT_W-1:0] used;
  } lookup_t;

  // store update for one word
  typedef struct packed {
    logic             en;
    logic             alloc;
    logic [IDX_W-1:0] idx;
  } write_t;

  // recency update for one word
  typedef struct packed {
    logic             en;
    logic             fresh;
    logic [IDX_W-1:0] idx;
  } touch_t;

endpackage

`default_nettype wire

@@ rtl/lvc_slot_store.sv @@
// key and kind storage with fill count and parallel key match
`default_nettype none

module lvc_slot_store (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [lvc_pkg::KEY_WIDTH-1:0] key,
  input  wire logic [lvc_pkg::KIND_W-1:0]    kind,
  input  wire lvc_pkg::write_t               wr,
  input  wire logic [lvc_pkg::IDX_W-1:0]     rd_idx,
  output lvc_pkg::lookup_t                   lookup,
  output logic [lvc_pkg::KEY_WIDTH-1:0]      rd_key,
  output logic [lvc_pkg::KIND_W-1:0]         rd_kind
);

  logic [lvc_pkg::KEY_WIDTH-1:0] slot_keys  [lvc_pkg::ENTRIES];
  logic [lvc_pkg::KIND_W-1:0]    slot_kinds [lvc_pkg::ENTRIES];
  logic [lvc_pkg::CNT_W-1:0]     used_count;
  logic [lvc_pkg::CNT_W-1:0]     used_count_next;

  // compare against every filled slot, lowest match wins
  always_comb begin
    lookup.hit     = 1'b0;
    lookup.hit_idx = '0;
    for (int i = lvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if ((lvc_pkg::CNT_W'(i) < used_count) && (slot_keys[i] == key)) begin
        lookup.hit     = 1'b1;
        lookup.hit_idx = lvc_pkg::IDX_W'(i);
      end
    end
    lookup.full = (used_count == lvc_pkg::CNT_W'(lvc_pkg::ENTRIES));
    lookup.used = used_count;
  end

  assign rd_key  = slot_keys[rd_idx];
  assign rd_kind = slot_kinds[rd_idx];

  assign used_count_next = (wr.en && wr.alloc) ? used_count + 1'b1 : used_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else begin
      used_count <= used_count_next;
    end
  end

  // payload, no reset: slots at or above the fill count are never read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      slot_keys[wr.idx]  <= key;
      slot_kinds[wr.idx] <= kind;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lvc_recency.sv @@
// per-slot recency ranks, victim select and most-recent update
`default_nettype none

module lvc_recency (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lvc_pkg::lookup_t          lookup,
  input  wire lvc_pkg::touch_t           touch,
  output logic [lvc_pkg::IDX_W-1:0]      victim_idx
);

  logic [lvc_pkg::RANK_W-1:0] rank      [lvc_pkg::ENTRIES];
  logic [lvc_pkg::RANK_W-1:0] rank_next [lvc_pkg::ENTRIES];
  logic [lvc_pkg::RANK_W:0]   old_rank;

  // oldest slot: ranks of filled slots form a permutation
  always_comb begin
    victim_idx = '0;
    for (int i = lvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if ((lvc_pkg::CNT_W'(i) < lookup.used) &&
          (rank[i] == lvc_pkg::RANK_W'(lvc_pkg::OLDEST_RANK))) begin
        victim_idx = lvc_pkg::IDX_W'(i);
      end
    end
  end

  // a fresh slot enters older than all others, so every filled slot ages
  assign old_rank = touch.fresh ? (lvc_pkg::RANK_W + 1)'(lvc_pkg::ENTRIES)
                                : {1'b0, rank[touch.idx]};

  always_comb begin
    for (int i = 0; i < lvc_pkg::ENTRIES; i++) begin
      rank_next[i] = rank[i];
      if (touch.en) begin
        if (lvc_pkg::IDX_W'(i) == touch.idx) begin
          rank_next[i] = '0;
        end else if ((lvc_pkg::CNT_W'(i) < lookup.used) &&
                     ({1'b0, rank[i]} < old_rank)) begin
          rank_next[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lvc_pkg::ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      for (int i = 0; i < lvc_pkg::ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/lru_value_cache.sv @@
// top level of the fully associative lru value cache
//
// channel   dir  tdata                                   tuser
// s_axis    in   key                                     value_kind
// m_axis    out  hit, slot, replaced, evicted_key, pad   stored_kind
//
// one word per cycle sustained while m_axis_tready stays high; a taken word
// goes from the input register to the result register through the single stage
// that matches the key against every slot, updating ranks and store in the same cycle
// synchronous reset empties the cache through the fill count, no clearing pass
// a stalled result holds in the output register while the input register
// still takes one more word, then s_axis_tready drops
`default_nettype none

module lru_value_cache (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [lvc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // key[63:0]
  input  wire logic [lvc_pkg::USER_W-1:0]      s_axis_tuser,  // value_kind[2:0], zeros
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // hit[0], slot[4:1], replaced[5], evicted_key[69:6], zeros
  output logic [lvc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [lvc_pkg::USER_W-1:0]           m_axis_tuser   // stored_kind[2:0], zeros
);

  // input register
  logic                          in_valid;
  logic [lvc_pkg::KEY_WIDTH-1:0] in_key;
  logic [lvc_pkg::KIND_W-1:0]    in_kind;

  // result register
  logic                          out_valid;
  logic                          out_hit;
  logic [lvc_pkg::SLOT_W-1:0]    out_slot;
  logic                          out_replaced;
  logic [lvc_pkg::KEY_PORT_W-1:0] out_evicted;
  logic [lvc_pkg::KIND_W-1:0]    out_kind;

  logic                          out_free;
  logic                          process;
  logic                          in_load;

  lvc_pkg::lookup_t              lookup;
  lvc_pkg::write_t               wr;
  lvc_pkg::touch_t               touch;
  logic [lvc_pkg::IDX_W-1:0]     victim_idx;
  logic [lvc_pkg::IDX_W-1:0]     sel_idx;
  logic [lvc_pkg::KEY_WIDTH-1:0] rd_key;
  logic [lvc_pkg::KIND_W-1:0]    rd_kind;
  logic                          replace;

  // widened copies for port-width conversion at any geometry
  logic [lvc_pkg::KEY_WIDTH+lvc_pkg::KEY_PORT_W-1:0] evicted_ext;
  logic [lvc_pkg::IDX_W+lvc_pkg::SLOT_W-1:0]         slot_ext;
  logic [lvc_pkg::KEY_PORT_W-1:0]                    evicted_next;
  logic [lvc_pkg::SLOT_W-1:0]                        slot_next;
  logic [lvc_pkg::KIND_W-1:0]                        kind_next;

  // handshakes: stage advances when the result register can take a word
  assign out_free      = !out_valid || m_axis_tready;
  assign process       = in_valid && out_free;
  assign s_axis_tready = !in_valid || process;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_key  <= s_axis_tdata[lvc_pkg::KEY_WIDTH-1:0];
      in_kind <= s_axis_tuser[lvc_pkg::KIND_W-1:0];
    end
  end

  lvc_slot_store u_store (
    .clk     (clk),
    .rst     (rst),
    .key     (in_key),
    .kind    (in_kind),
    .wr      (wr),
    .rd_idx  (sel_idx),
    .lookup  (lookup),
    .rd_key  (rd_key),
    .rd_kind (rd_kind)
  );

  lvc_recency u_recency (
    .clk        (clk),
    .rst        (rst),
    .lookup     (lookup),
    .touch      (touch),
    .victim_idx (victim_idx)
  );

  // slot choice: hit slot, else next free slot, else least recent
  always_comb begin
    priority if (lookup.hit) begin
      sel_idx = lookup.hit_idx;
    end else if (!lookup.full) begin
      sel_idx = lookup.used[lvc_pkg::IDX_W-1:0];
    end else begin
      sel_idx = victim_idx;
    end
  end

  assign replace = !lookup.hit && lookup.full;

  // store writes on every miss, fill count grows only while not full
  assign wr.en    = process && !lookup.hit;
  assign wr.alloc = !lookup.full;
  assign wr.idx   = sel_idx;

  assign touch.en    = process;
  assign touch.fresh = !lookup.hit && !lookup.full;
  assign touch.idx   = sel_idx;

  // old key is read before the write lands at the clock edge
  assign evicted_ext  = {{lvc_pkg::KEY_PORT_W{1'b0}}, (replace ? rd_key : '0)};
  assign evicted_next = evicted_ext[lvc_pkg::KEY_PORT_W-1:0];
  assign slot_ext     = {{lvc_pkg::SLOT_W{1'b0}}, sel_idx};
  assign slot_next    = slot_ext[lvc_pkg::SLOT_W-1:0];
  // a hit reports the stored kind, a fill reports the new one
  assign kind_next    = lookup.hit ? rd_kind : in_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_hit      <= lookup.hit;
      out_slot     <= slot_next;
      out_replaced <= replace;
      out_evicted  <= evicted_next;
      out_kind     <= kind_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{lvc_pkg::OUT_PAD_W{1'b0}}, out_evicted, out_replaced,
                          out_slot, out_hit};
  assign m_axis_tuser  = {{(lvc_pkg::USER_W - lvc_pkg::KIND_W){1'b0}}, out_kind};

  // a word never both hits and evicts
  a_hit_no_replace: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_hit && out_replaced))
    else $error("result marks both hit and replaced");

  // evicted key is zero unless something was replaced
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_replaced) |-> (out_evicted == '0))
    else $error("evicted key nonzero without replacement");

  // a miss on a cache that is not full takes exactly one new slot
  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (process && !lookup.hit && !lookup.full) |=>
      (lookup.used == $past(lookup.used) + 1'b1))
    else $error("fill count did not advance on allocation");

  // fill count stays within the slot count
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    lookup.used <= lvc_pkg::CNT_W'(lvc_pkg::ENTRIES))
    else $error("fill count beyond slot count");

endmodule

`default_nettype wire

@@ tb/sv/tb_lru_value_cache.sv @@
// self-checking testbench for the lru value cache, streaming lookups against a cache predictor
`timescale 1ns / 100ps

module tb_lru_value_cache;
  import lvc_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 650;
  localparam int POOL_SIZE      = 24;
  localparam int HOT_SIZE       = 6;
  localparam int MAX_REPORTS    = 10;

  localparam logic [63:0] KEY_MASK =
    (KEY_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << KEY_WIDTH) - 64'd1);

  typedef enum logic [KIND_W-1:0] {
    KIND_MOLECULE  = 3'd0,
    KIND_BIT_FP    = 3'd1,
    KIND_SPARSE_FP = 3'd2,
    KIND_REACTION  = 3'd3,
    KIND_QUERY_MOL = 3'd4
  } value_kind_e;

  // kinds past the defined encodings, stored as plain 3-bit values
  localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_TOP = 3'd7;

  typedef struct {
    logic [63:0]       key;
    logic [KIND_W-1:0] kind;
    bit                drain;  // hold off until every result is back
  } lookup_req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              replaced;
    logic [63:0]       evicted_key;
    logic [KIND_W-1:0] stored_kind;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [USER_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [USER_W-1:0]      m_axis_tuser;

  lru_value_cache u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // key[63:0]
    .s_axis_tuser  (s_axis_tuser),   // value_kind[2:0], zeros
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // hit[0], slot[4:1], replaced[5], evicted_key[69:6], zeros
    .m_axis_tuser  (m_axis_tuser)    // stored_kind[2:0], zeros
  );

  always #CLK_HALF clk = ~clk;

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // predictor copy of the cache contents and the recency order
  logic [63:0]       cached_key  [ENTRIES];
  logic [KIND_W-1:0] cached_kind [ENTRIES];
  int                cached_age  [ENTRIES];  // 0 = most recent
  int                fill_count = 0;

  lookup_req_t pending_q [$];
  lookup_res_t expected_q[$];

  int fail_count  = 0;
  int idle_cycles = 0;
  bit in_taken    = 1'b0;
  int gap_left    = 0;
  int burst_left  = 0;
  lookup_req_t drive_req;
  logic [7:0]  stall_phase = '0;

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_lookup(input logic [63:0] key, input logic [KIND_W-1:0] kind,
                                       input bit drain);
    lookup_req_t req;
    req.key   = key;
    req.kind  = kind;
    req.drain = drain;
    pending_q.push_back(req);
  endfunction

  // slot s becomes most recent, every valid slot younger than it ages by one
  function automatic void make_recent(input int s, input int old_age);
    for (int i = 0; i < fill_count; i++) begin
      if (i != s && cached_age[i] < old_age) cached_age[i]++;
    end
    cached_age[s] = 0;
  endfunction

  function automatic lookup_res_t predict_lookup(input logic [63:0] key_in,
                                                 input logic [KIND_W-1:0] kind_in);
    lookup_res_t res;
    logic [63:0] k;
    int          s;
    int          oldest;
    bit          found;
    res   = '0;
    k     = key_in & KEY_MASK;
    s     = 0;
    found = 1'b0;
    for (int i = 0; i < fill_count; i++) begin
      if (!found && cached_key[i] == k) begin
        s     = i;
        found = 1'b1;
      end
    end
    if (found) begin
      // hit keeps the stored kind, the requested one is dropped
      res.hit = 1'b1;
      make_recent(s, cached_age[s]);
    end else if (fill_count < ENTRIES) begin
      s = fill_count;
      fill_count++;
      cached_key[s]  = k;
      cached_kind[s] = kind_in;
      make_recent(s, ENTRIES);
    end else begin
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (cached_age[i] > oldest) begin
          oldest = cached_age[i];
          s      = i;
        end
      end
      res.replaced    = 1'b1;
      res.evicted_key = cached_key[s] & KEY_MASK;
      cached_key[s]   = k;
      cached_kind[s]  = kind_in;
      make_recent(s, cached_age[s]);
    end
    res.slot        = s[SLOT_W-1:0];
    res.stored_kind = cached_kind[s];
    return res;
  endfunction

  task automatic note_failure(input string what, input lookup_res_t want, input lookup_res_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s: expected hit=%0d slot=%0d replaced=%0d evicted=%h kind=%0d", what,
               want.hit, want.slot, want.replaced, want.evicted_key, want.stored_kind);
      $display("%s: actual   hit=%0d slot=%0d replaced=%0d evicted=%h kind=%0d", what,
               got.hit, got.slot, got.replaced, got.evicted_key, got.stored_kind);
    end
  endtask

  // request driver: bursts with random gaps, changes on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (pending_q[0].drain && expected_q.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        drive_req = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= drive_req.key;
        s_axis_tuser  <= {{(USER_W-KIND_W){1'b0}}, drive_req.kind};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // result receiver: stall mode follows the top two bits of a free-running phase counter
  always @(negedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 9) < 7);
      2'd2: m_axis_tready <= (stall_phase[2:0] > 3'd2);
      default: m_axis_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  // monitor: predict on each taken request word, check each result word
  always @(posedge clk) begin
    lookup_res_t got;
    lookup_res_t want;
    if (!rst) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(predict_lookup(s_axis_tdata, s_axis_tuser[KIND_W-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit         = m_axis_tdata[0];
        got.slot        = m_axis_tdata[SLOT_W:1];
        got.replaced    = m_axis_tdata[SLOT_W+1];
        got.evicted_key = m_axis_tdata[SLOT_W+2 +: 64];
        got.stored_kind = m_axis_tuser[KIND_W-1:0];
        if (expected_q.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) note_failure("mismatch", want, got);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [63:0] pool [POOL_SIZE];
    logic [63:0] k;
    int          r;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = rand_key();

    // extreme keys, then hits that ask for a different kind
    queue_lookup(64'd0, KIND_MOLECULE, 1'b0);
    queue_lookup({64{1'b1}}, KIND_SPARE_TOP, 1'b0);
    queue_lookup(64'd0, KIND_QUERY_MOL, 1'b0);
    queue_lookup({64{1'b1}}, KIND_MOLECULE, 1'b0);
    // fill the remaining slots, every kind code on the way
    for (int i = 0; i < ENTRIES - 2; i++)
      queue_lookup({32{2'b10}} ^ (64'd1 << (i * 4 + 1)), KIND_W'((i + 1) % 8), 1'b0);
    // full cache: evictions of the oldest slots, hits on refilled ones
    queue_lookup(64'h8000_0000_0000_0000, KIND_SPARE_LO, 1'b0);
    queue_lookup(64'd0, KIND_SPARE_MID, 1'b0);
    queue_lookup(64'h8000_0000_0000_0000, KIND_BIT_FP, 1'b0);
    queue_lookup({64{1'b1}}, KIND_REACTION, 1'b0);
    queue_lookup({64{1'b1}}, KIND_SPARSE_FP, 1'b0);

    // working set a bit larger than the cache, hot subset, fresh and corner keys
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, POOL_SIZE - 1)] = rand_key();
      if (r < 50) begin
        k = pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (r < 80) begin
        k = pool[$urandom_range(0, HOT_SIZE - 1)];
      end else if (r < 92) begin
        k = rand_key();
      end else begin
        case ($urandom_range(0, 2))
          0: k = 64'd0;
          1: k = {64{1'b1}};
          default: k = 64'd1 << $urandom_range(0, 63);
        endcase
      end
      queue_lookup(k, KIND_W'($urandom_range(0, 7)), (n % 200) == 0);
    end

    wait (!rst);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    #1;
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
